[design/cubic_bezier_tessellator_unit_macros.svh]
`ifndef CUBIC_BEZIER_TESSELLATOR_UNIT_MACROS_SVH
`define CUBIC_BEZIER_TESSELLATOR_UNIT_MACROS_SVH

// Next-cycle implication, switched off while reset is high.
`define CBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Plain property on the clock, also checked during reset.
`define CBT_ASSERT_RAW(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/cbt_pkg.sv]
package cbt_pkg;

  localparam int COORD_BITS     = 16;
  localparam int FRAC_BITS      = 4;
  localparam int MAX_STEPS_LOG2 = 6;

  localparam int CFG_BITS = 3;
  localparam logic [CFG_BITS-1:0] STEPS_LOG2_RESET = 3'd6;

  // Control points per segment: start, end, ctrl1, ctrl2, each as x and y.
  localparam int NUM_COORDS = 8;

  // Coordinate slots inside a segment word, x at the slot and y one above.
  localparam int SLOT_START = 0;
  localparam int SLOT_END   = 2;
  localparam int SLOT_CTRL1 = 4;
  localparam int SLOT_CTRL2 = 6;

  function automatic int byte_align(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

[design/cbt_eval.sv]
module cbt_eval #(
  parameter int COORD_BITS     = cbt_pkg::COORD_BITS,
  parameter int FRAC_BITS      = cbt_pkg::FRAC_BITS,
  parameter int MAX_STEPS_LOG2 = cbt_pkg::MAX_STEPS_LOG2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                issue_valid,
  input  logic                                issue_last,
  input  logic [cbt_pkg::CFG_BITS-1:0]        issue_lg,
  input  logic [MAX_STEPS_LOG2:0]             issue_k,
  input  logic [MAX_STEPS_LOG2:0]             issue_u,
  input  logic signed [COORD_BITS-1:0]        issue_c [cbt_pkg::NUM_COORDS],
  output logic                                adv,
  output logic                                point_valid,
  input  logic                                point_ready,
  output logic [COORD_BITS+FRAC_BITS-1:0]     point_x,
  output logic [COORD_BITS+FRAC_BITS-1:0]     point_y,
  output logic                                point_last
);

  localparam int KW    = MAX_STEPS_LOG2 + 1;
  localparam int WB    = 3 * KW + 2;
  localparam int PW    = COORD_BITS + WB + 1;
  localparam int ACC_W = PW + 2;
  localparam int SW    = ACC_W + FRAC_BITS + 1;
  localparam int DW    = $clog2(3 * MAX_STEPS_LOG2 + 1);
  localparam int OUT_W = COORD_BITS + FRAC_BITS;
  localparam int NC    = cbt_pkg::NUM_COORDS;

  logic [7:1] v;
  logic [7:1] l;
  logic [DW-1:0] d [1:7];

  logic [KW-1:0] k1, u1, k2, u2;
  logic [2*KW-1:0] ksq2, usq2, ku2;
  logic [WB-1:0] w3 [4];
  logic [3*KW-1:0] kuu, kuk;
  logic signed [COORD_BITS-1:0] c1 [NC];
  logic signed [COORD_BITS-1:0] c2 [NC];
  logic signed [COORD_BITS-1:0] c3 [NC];
  logic signed [PW-1:0] prod4 [2][4];
  logic signed [ACC_W-1:0] pair5 [2][2];
  logic signed [ACC_W-1:0] sum6 [2];
  logic signed [SW-1:0] rnd7 [2];
  logic signed [SW-1:0] rnd_add;
  logic signed [SW-1:0] shifted [2];

  // The whole pipe moves together; it holds only while a result word waits.
  assign adv = !point_valid || point_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      point_valid <= 1'b0;
    end else if (adv) begin
      v <= {v[6:1], issue_valid};
      point_valid <= v[7];
    end
  end

  assign kuu = (3*KW)'(ku2) * (3*KW)'(u2);
  assign kuk = (3*KW)'(ku2) * (3*KW)'(k2);
  assign rnd_add = (d[6] == '0) ? '0 : (SW'(1) <<< (d[6] - 1'b1));

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      shifted[a] = rnd7[a] >>> d[7];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l <= {l[6:1], issue_last};
      point_last <= l[7];
      d[1] <= DW'(3 * issue_lg);
      for (int s = 2; s <= 7; s++) begin
        d[s] <= d[s-1];
      end

      // Stage 1: step index and its complement.
      k1 <= issue_k;
      u1 <= issue_u;
      c1 <= issue_c;

      // Stage 2: squares and cross term.
      ksq2 <= (2*KW)'(k1) * (2*KW)'(k1);
      usq2 <= (2*KW)'(u1) * (2*KW)'(u1);
      ku2  <= (2*KW)'(k1) * (2*KW)'(u1);
      k2   <= k1;
      u2   <= u1;
      c2   <= c1;

      // Stage 3: Bernstein weights scaled by N^3.
      w3[0] <= WB'((3*KW)'(usq2) * (3*KW)'(u2));
      w3[1] <= WB'(kuu) + (WB'(kuu) << 1);
      w3[2] <= WB'(kuk) + (WB'(kuk) << 1);
      w3[3] <= WB'((3*KW)'(ksq2) * (3*KW)'(k2));
      c3   <= c2;

      // Stage 4: one product per control point and axis.
      for (int a = 0; a < 2; a++) begin
        prod4[a][0] <= PW'(c3[cbt_pkg::SLOT_START + a]) * PW'($signed({1'b0, w3[0]}));
        prod4[a][1] <= PW'(c3[cbt_pkg::SLOT_CTRL1 + a]) * PW'($signed({1'b0, w3[1]}));
        prod4[a][2] <= PW'(c3[cbt_pkg::SLOT_CTRL2 + a]) * PW'($signed({1'b0, w3[2]}));
        prod4[a][3] <= PW'(c3[cbt_pkg::SLOT_END + a]) * PW'($signed({1'b0, w3[3]}));
      end

      // Stages 5 and 6: adder tree.
      for (int a = 0; a < 2; a++) begin
        pair5[a][0] <= ACC_W'(prod4[a][0]) + ACC_W'(prod4[a][1]);
        pair5[a][1] <= ACC_W'(prod4[a][2]) + ACC_W'(prod4[a][3]);
        sum6[a] <= pair5[a][0] + pair5[a][1];
      end

      // Stage 7: scale to the output fraction and add half the divisor.
      for (int a = 0; a < 2; a++) begin
        rnd7[a] <= (SW'(sum6[a]) <<< FRAC_BITS) + rnd_add;
      end

      // Output: divide by N^3 with an arithmetic shift, which floors.
      point_x <= shifted[0][OUT_W-1:0];
      point_y <= shifted[1][OUT_W-1:0];
    end
  end

endmodule

[design/cubic_bezier_tessellator_unit.sv]
// Cubic Bezier tessellator.
// Slave stream: one word per curve segment carrying start, end and the two
// control points as signed integer coordinates. Master stream: one word per
// curve point, x and y in fixed point with FRAC_BITS fraction bits, rounded
// to nearest; tlast marks the final point of a segment.
// A segment yields N = 2^steps_log2 points at t = k/N, k = 0..N-1 (the end
// point is not emitted). steps_log2 is written through cfg_we and cfg_data
// only while the block is idle; the user must ensure it, the block does not.
// Values above MAX_STEPS_LOG2 act as the maximum; it resets to 6 (64 points).
// Throughput: one point per cycle while the receiver does not stall. A
// segment holds the issue counter until all N of its points are issued; the
// next segment is taken in the cycle its predecessor issues its last point.
// The first point of a segment reaches the master side through the issue
// register, seven arithmetic stages and the output register.
// Reset clears the pipeline valid bits, the output valid bit and the segment
// slot, and sets steps_log2 to 6. When the receiver stalls, the whole pipe
// holds; no point is lost or repeated.
module cubic_bezier_tessellator_unit #(
  parameter int COORD_BITS     = cbt_pkg::COORD_BITS,
  parameter int FRAC_BITS      = cbt_pkg::FRAC_BITS,
  parameter int MAX_STEPS_LOG2 = cbt_pkg::MAX_STEPS_LOG2
) (
  input  logic clk,
  input  logic rst,
  input  logic                          cfg_we,
  input  logic [cbt_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // start_x, start_y, end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
  input  logic [cbt_pkg::byte_align(cbt_pkg::NUM_COORDS*COORD_BITS)-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // point_x, point_y, zero fill
  output logic [cbt_pkg::byte_align(2*(COORD_BITS+FRAC_BITS))-1:0] m_axis_tdata,
  output logic m_axis_tlast
);

  localparam int KW    = MAX_STEPS_LOG2 + 1;
  localparam int OUT_W = COORD_BITS + FRAC_BITS;
  localparam int OUT_DW = cbt_pkg::byte_align(2 * OUT_W);
  localparam int NC    = cbt_pkg::NUM_COORDS;

  logic [cbt_pkg::CFG_BITS-1:0] steps_log2;
  logic [cbt_pkg::CFG_BITS-1:0] lg_sat;
  logic                         seg_valid;
  logic [cbt_pkg::CFG_BITS-1:0] seg_lg;
  logic [KW-1:0]                seg_k;
  logic [KW-1:0]                seg_n;
  logic [KW-1:0]                seg_u;
  logic signed [COORD_BITS-1:0] seg_c [NC];
  logic                         issue_last;
  logic                         adv;
  logic                         take;
  logic [OUT_W-1:0]             point_x;
  logic [OUT_W-1:0]             point_y;

  assign lg_sat = (steps_log2 > cbt_pkg::CFG_BITS'(MAX_STEPS_LOG2))
                ? cbt_pkg::CFG_BITS'(MAX_STEPS_LOG2) : steps_log2;

  assign seg_n      = KW'(1) << seg_lg;
  assign seg_u      = seg_n - seg_k;
  assign issue_last = (seg_k == seg_n - 1'b1);

  // The slot frees up in the same cycle that its last point is issued into the pipe.
  assign s_axis_tready = !seg_valid || (adv && issue_last);
  assign take = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_log2 <= cbt_pkg::STEPS_LOG2_RESET;
      seg_valid  <= 1'b0;
      seg_k      <= '0;
    end else begin
      if (cfg_we) begin
        steps_log2 <= cfg_data;
      end
      if (take) begin
        seg_valid <= 1'b1;
        seg_k     <= '0;
      end else if (seg_valid && adv) begin
        if (issue_last) begin
          seg_valid <= 1'b0;
        end
        seg_k <= seg_k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      seg_lg <= lg_sat;
      for (int i = 0; i < NC; i++) begin
        seg_c[i] <= s_axis_tdata[i*COORD_BITS +: COORD_BITS];
      end
    end
  end

  cbt_eval #(
    .COORD_BITS     (COORD_BITS),
    .FRAC_BITS      (FRAC_BITS),
    .MAX_STEPS_LOG2 (MAX_STEPS_LOG2)
  ) u_eval (
    .clk         (clk),
    .rst         (rst),
    .issue_valid (seg_valid),
    .issue_last  (issue_last),
    .issue_lg    (seg_lg),
    .issue_k     (seg_k),
    .issue_u     (seg_u),
    .issue_c     (seg_c),
    .adv         (adv),
    .point_valid (m_axis_tvalid),
    .point_ready (m_axis_tready),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_last  (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_DW'({point_y, point_x});

endmodule

[design/cbt_checker.sv]
module cbt_checker #(
  parameter int DATA_W = cbt_pkg::byte_align(2 * (cbt_pkg::COORD_BITS + cbt_pkg::FRAC_BITS))
) (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic              m_axis_tlast
);

`include "cubic_bezier_tessellator_unit_macros.svh"

  logic stalled;

  assign stalled = m_axis_tvalid && !m_axis_tready;

  // A word that waits must stay put.
  `CBT_ASSERT_NEXT(a_hold, stalled, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tlast}), "stalled word changed")

  // Reset empties both the output register and the segment slot.
  `CBT_ASSERT_RAW(a_reset, rst |=> (!m_axis_tvalid && s_axis_tready), "block not empty after reset")

  // Points need the full pipeline to come out after reset ends.
  `CBT_ASSERT_RAW(a_latency, $fell(rst) |-> ##2 !m_axis_tvalid, "result word too early after reset")

  // A busy segment slot cannot free up while the output stays stalled.
  `CBT_ASSERT_NEXT(a_slot, stalled && !s_axis_tready, !s_axis_tready || m_axis_tready, "slot freed in stall")

endmodule

bind cubic_bezier_tessellator_unit cbt_checker #(
  .DATA_W ($bits(m_axis_tdata))
) u_cbt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[verif/tb_cubic_bezier_tessellator_unit.sv]
`timescale 1ns / 100ps

module tb_cubic_bezier_tessellator_unit;

  localparam int COORD_BITS     = cbt_pkg::COORD_BITS;
  localparam int FRAC_BITS      = cbt_pkg::FRAC_BITS;
  localparam int MAX_STEPS_LOG2 = cbt_pkg::MAX_STEPS_LOG2;
  localparam int CFG_BITS       = cbt_pkg::CFG_BITS;
  localparam int OUT_W      = COORD_BITS + FRAC_BITS;
  localparam int IN_DATA_W  = cbt_pkg::byte_align(cbt_pkg::NUM_COORDS * COORD_BITS);
  localparam int OUT_DATA_W = cbt_pkg::byte_align(2 * OUT_W);
  localparam int SETTLE_CYCLES = 12;
  localparam int SEGS_PER_SETTING = 45;
  localparam int TIMEOUT_NS = 50_000_000;

  // Packed so that start_x lands in the lowest bits of the word.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] ctrl2_y;
    logic signed [COORD_BITS-1:0] ctrl2_x;
    logic signed [COORD_BITS-1:0] ctrl1_y;
    logic signed [COORD_BITS-1:0] ctrl1_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_x;
  } segment_t;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic                    last;
  } curve_point_t;

  typedef struct {
    bit                   cfg_wr;
    logic [CFG_BITS-1:0]  cfg_val;
    segment_t             seg;
    bit                   typed;
    logic signed [OUT_W-1:0] exp_x;
    logic signed [OUT_W-1:0] exp_y;
  } seg_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_BITS-1:0]    cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // start_x, start_y, end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // point_x, point_y, zero fill
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tlast;

  curve_point_t        curve_points_due[$];
  seg_row_t            seg_table[$];
  logic [CFG_BITS-1:0] steps_setting = cbt_pkg::STEPS_LOG2_RESET;
  bit                  quiet = 1'b0;
  int                  fail_count = 0;
  int                  points_checked = 0;
  int                  segs_sent = 0;

  cubic_bezier_tessellator_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Bernstein sum scaled by N^3, then brought to FRAC_BITS fraction bits with
  // round half up.
  function automatic logic [OUT_W-1:0] bernstein_axis(longint s, longint c1, longint c2,
                                                      longint e, longint k, int lg);
    longint n;
    longint u;
    longint acc;
    int     sh;
    n = longint'(1) << lg;
    u = n - k;
    acc = s * u * u * u + 3 * c1 * k * u * u + 3 * c2 * k * k * u + e * k * k * k;
    if (3 * lg >= FRAC_BITS) begin
      sh = 3 * lg - FRAC_BITS;
      if (sh > 0) acc = (acc + (longint'(1) << (sh - 1))) >>> sh;
    end else begin
      acc = acc * (longint'(1) << (FRAC_BITS - 3 * lg));
    end
    return acc[OUT_W-1:0];
  endfunction

  task automatic queue_point(input curve_point_t pt);
    curve_points_due.insert(curve_points_due.size(), pt);
  endtask

  task automatic add_row(input seg_row_t r);
    seg_table.insert(seg_table.size(), r);
  endtask

  task automatic predict_curve(input segment_t seg);
    int           lg;
    int           n;
    curve_point_t pt;
    lg = (steps_setting > MAX_STEPS_LOG2) ? MAX_STEPS_LOG2 : int'(steps_setting);
    n = 1 << lg;
    for (int k = 0; k < n; k++) begin
      pt.x = bernstein_axis(seg.start_x, seg.ctrl1_x, seg.ctrl2_x, seg.end_x, k, lg);
      pt.y = bernstein_axis(seg.start_y, seg.ctrl1_y, seg.ctrl2_y, seg.end_y, k, lg);
      pt.last = (k == n - 1);
      queue_point(pt);
    end
  endtask

  function automatic seg_row_t mk_row(bit wr, int val, int sx, int sy, int ex, int ey,
                                      int c1x, int c1y, int c2x, int c2y,
                                      bit typed, int px, int py);
    seg_row_t r;
    r.cfg_wr = wr;
    r.cfg_val = val[CFG_BITS-1:0];
    r.seg.start_x = sx[COORD_BITS-1:0];
    r.seg.start_y = sy[COORD_BITS-1:0];
    r.seg.end_x = ex[COORD_BITS-1:0];
    r.seg.end_y = ey[COORD_BITS-1:0];
    r.seg.ctrl1_x = c1x[COORD_BITS-1:0];
    r.seg.ctrl1_y = c1y[COORD_BITS-1:0];
    r.seg.ctrl2_x = c2x[COORD_BITS-1:0];
    r.seg.ctrl2_y = c2y[COORD_BITS-1:0];
    r.typed = typed;
    r.exp_x = px[OUT_W-1:0];
    r.exp_y = py[OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return COORD_BITS'($urandom_range(0, 15) - 8);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic segment_t rand_segment();
    segment_t s;
    s.start_x = rand_coord();
    s.start_y = rand_coord();
    s.end_x   = rand_coord();
    s.end_y   = rand_coord();
    s.ctrl1_x = rand_coord();
    s.ctrl1_y = rand_coord();
    s.ctrl2_x = rand_coord();
    s.ctrl2_y = rand_coord();
    return s;
  endfunction

  task automatic drain_points();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (curve_points_due.size() != 0);
  endtask

  // The setting may only change with the pipe empty.
  task automatic set_steps(input logic [CFG_BITS-1:0] val);
    drain_points();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= val;
    steps_setting = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Leaves tvalid high so back-to-back words need no extra assignment.
  task automatic send_segment(input segment_t seg);
    s_axis_tdata <= seg;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    segs_sent++;
  endtask

  always begin
    @(posedge clk);
    if (!quiet && !rst && $urandom_range(0, 9) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk) begin
    curve_point_t            due;
    logic signed [OUT_W-1:0] got_x;
    logic signed [OUT_W-1:0] got_y;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_x = m_axis_tdata[OUT_W-1:0];
      got_y = m_axis_tdata[2*OUT_W-1:OUT_W];
      if (curve_points_due.size() == 0) begin
        $error("unexpected curve point x=%0d y=%0d last=%0b", got_x, got_y, m_axis_tlast);
        fail_count++;
      end else begin
        due = curve_points_due.pop_front();
        points_checked++;
        if (got_x !== due.x) begin
          $error("point_x: expected %0d, got %0d", due.x, got_x);
          fail_count++;
        end
        if (got_y !== due.y) begin
          $error("point_y: expected %0d, got %0d", due.y, got_y);
          fail_count++;
        end
        if (m_axis_tlast !== due.last) begin
          $error("last_point: expected %0b, got %0b", due.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    logic [CFG_BITS-1:0] random_steps[8];
    curve_point_t        pt;
    random_steps = '{3'd3, 3'd0, 3'd7, 3'd1, 3'd5, 3'd2, 3'd4, 3'd6};

    // Rows without a write first run on the reset setting of 64 points.
    add_row(mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(0, 0, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                   0, 0, 0));
    add_row(mk_row(0, 0, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                   -32768, 0, 0, 0));
    // One point per segment: just the start point scaled by 16.
    add_row(mk_row(1, 0, 32767, -32768, 100, -200, 5, 7, -9, 11, 1, 524272,
                   -524288));
    add_row(mk_row(0, 0, -1, 1, 32767, -32768, -32768, 32767, 32767, 32767, 1,
                   -16, 16));
    add_row(mk_row(0, 0, 0, 0, -32768, -32768, 32767, -32768, -32768, 32767, 1,
                   0, 0));
    // A setting above the maximum acts as the maximum.
    add_row(mk_row(1, 7, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
                   -32768, 0, 0, 0));
    add_row(mk_row(0, 0, 32767, 32767, -32768, -32768, -32768, 32767, 32767,
                   -32768, 0, 0, 0));
    add_row(mk_row(1, 1, -32768, 32767, 32767, -32768, 32767, -32768, -32768,
                   32767, 0, 0, 0));
    // Exact halves at k = 1 with four points: ties must round upward.
    add_row(mk_row(1, 2, 0, 0, 2, -2, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(0, 0, 0, 0, 6, -6, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(0, 0, -32768, 32767, 32767, -32768, -32768, -32768, 32767,
                   32767, 0, 0, 0));
    add_row(mk_row(1, 3, 32767, -32768, -32768, 32767, 32767, 32767, -32768,
                   -32768, 0, 0, 0));
    add_row(mk_row(1, 4, -32768, -32768, 32767, 32767, 32767, -32768, -32768,
                   32767, 0, 0, 0));
    add_row(mk_row(1, 5, 1, -1, -1, 1, 32767, -32768, -32768, 32767, 0, 0, 0));
    add_row(mk_row(1, 6, -32768, 32767, -32768, 32767, 32767, -32768, 32767,
                   -32768, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (seg_table[i]) begin
      if (seg_table[i].cfg_wr) set_steps(seg_table[i].cfg_val);
      sender_gap();
      send_segment(seg_table[i].seg);
      if (seg_table[i].typed) begin
        pt.x = seg_table[i].exp_x;
        pt.y = seg_table[i].exp_y;
        pt.last = 1'b1;
        queue_point(pt);
      end else begin
        predict_curve(seg_table[i].seg);
      end
    end

    // The last setting runs with no idling on either side.
    foreach (random_steps[p]) begin
      set_steps(random_steps[p]);
      quiet = (p == 7);
      for (int i = 0; i < SEGS_PER_SETTING; i++) begin
        segment_t seg;
        if (p == 2 && i == 20) drain_points();
        sender_gap();
        seg = rand_segment();
        send_segment(seg);
        predict_curve(seg);
      end
    end

    drain_points();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d segments under step settings 0 through 7 and checked %0d points.",
             segs_sent, points_checked);
    if (fail_count == 0 && curve_points_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/cbt_pkg.sv
design/cbt_eval.sv
design/cubic_bezier_tessellator_unit.sv
design/cbt_checker.sv
verif/tb_cubic_bezier_tessellator_unit.sv
